@@ hw/rtl/rtyuv_pkg.sv @@
package rtyuv_pkg;

  // Field widths.
  localparam int unsigned CoordW   = 12;
  localparam int unsigned CompW    = 8;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned FwidthW  = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned StrideW  = FwidthW + 1;

  // Reset values of the configuration registers.
  localparam logic [FwidthW-1:0] PicWidthRst = FwidthW'(640);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIC_WIDTH   = 1'b0,
    CFG_CHROMA_MODE = 1'b1
  } cfg_idx_e;

  // Chroma layouts.  The unused code behaves as 4:2:2.
  typedef enum logic [1:0] {
    CM_420 = 2'd0,
    CM_422 = 2'd1,
    CM_444 = 2'd2
  } chroma_mode_e;

  // One input pixel.
  typedef struct packed {
    logic [CoordW-1:0] x_pos;
    logic [CoordW-1:0] y_pos;
    logic [CompW-1:0]  red;
    logic [CompW-1:0]  green;
    logic [CompW-1:0]  blue;
  } pix_t;

  // One result.
  typedef struct packed {
    logic [AddrW-1:0] luma_address;
    logic [CompW-1:0] luma;
    logic             chroma_write;
    logic [AddrW-1:0] chroma_address;
    logic [CompW-1:0] cb_value;
    logic [CompW-1:0] cr_value;
  } res_t;

  // Address unit outputs.
  typedef struct packed {
    logic [AddrW-1:0] luma_address;
    logic             chroma_write;
    logic [AddrW-1:0] chroma_address;
  } addr_t;

endpackage

@@ hw/rtl/rtyuv_pix_if.sv @@
interface rtyuv_pix_if;
  import rtyuv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] x_pos;
  logic [CoordW-1:0] y_pos;
  logic [CompW-1:0]  red;
  logic [CompW-1:0]  green;
  logic [CompW-1:0]  blue;

  modport source (output valid, x_pos, y_pos, red, green, blue, input ready);
  modport sink   (input valid, x_pos, y_pos, red, green, blue, output ready);

endinterface

@@ hw/rtl/rtyuv_res_if.sv @@
interface rtyuv_res_if;
  import rtyuv_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] luma_address;
  logic [CompW-1:0] luma;
  logic             chroma_write;
  logic [AddrW-1:0] chroma_address;
  logic [CompW-1:0] cb_value;
  logic [CompW-1:0] cr_value;

  modport source (output valid, luma_address, luma, chroma_write, chroma_address,
                  cb_value, cr_value, input ready);
  modport sink   (input valid, luma_address, luma, chroma_write, chroma_address,
                  cb_value, cr_value, output ready);

endinterface

@@ hw/rtl/rtyuv_color.sv @@
module rtyuv_color (
  input  logic [rtyuv_pkg::CompW-1:0] red_i,
  input  logic [rtyuv_pkg::CompW-1:0] green_i,
  input  logic [rtyuv_pkg::CompW-1:0] blue_i,
  output logic [rtyuv_pkg::CompW-1:0] luma_o,
  output logic [rtyuv_pkg::CompW-1:0] cb_o,
  output logic [rtyuv_pkg::CompW-1:0] cr_o
);
  import rtyuv_pkg::*;

  // Q16 weights with the chroma divisors folded in.
  localparam int unsigned AccW = 26;
  localparam logic [AccW-1:0] KYR = AccW'(19595);
  localparam logic [AccW-1:0] KYG = AccW'(38470);
  localparam logic [AccW-1:0] KYB = AccW'(7471);
  localparam logic [AccW-1:0] KUR = AccW'(11058);
  localparam logic [AccW-1:0] KUG = AccW'(21710);
  localparam logic [AccW-1:0] KUB = AccW'(32768);
  localparam logic [AccW-1:0] KVR = AccW'(32768);
  localparam logic [AccW-1:0] KVG = AccW'(27439);
  localparam logic [AccW-1:0] KVB = AccW'(5329);
  localparam logic [AccW-1:0] HalfOff = AccW'(8355840);

  // A negative sum gives zero, otherwise the integer part limited to 255.
  function automatic logic [CompW-1:0] clamp_q16(input logic signed [AccW:0] acc);
    logic [CompW-1:0] res;
    if (acc[AccW]) begin
      res = '0;
    end else if (|acc[AccW-1:16+CompW]) begin
      res = '1;
    end else begin
      res = acc[16+CompW-1:16];
    end
    return res;
  endfunction

  logic [AccW-1:0] r_w, g_w, b_w;
  logic [AccW-1:0] y_sum;
  logic [AccW-1:0] u_pos, u_neg, v_pos, v_neg;
  logic signed [AccW:0] y_acc, u_acc, v_acc;

  assign r_w = AccW'(red_i);
  assign g_w = AccW'(green_i);
  assign b_w = AccW'(blue_i);

  // Weighted sums, split into added and subtracted terms.
  assign y_sum = r_w * KYR + g_w * KYG + b_w * KYB;
  assign u_pos = HalfOff + b_w * KUB;
  assign u_neg = r_w * KUR + g_w * KUG;
  assign v_pos = HalfOff + r_w * KVR;
  assign v_neg = g_w * KVG + b_w * KVB;

  assign y_acc = $signed({1'b0, y_sum});
  assign u_acc = $signed({1'b0, u_pos}) - $signed({1'b0, u_neg});
  assign v_acc = $signed({1'b0, v_pos}) - $signed({1'b0, v_neg});

  assign luma_o = clamp_q16(y_acc);
  assign cb_o   = clamp_q16(u_acc);
  assign cr_o   = clamp_q16(v_acc);

endmodule

@@ hw/rtl/rtyuv_addr.sv @@
module rtyuv_addr (
  input  logic [rtyuv_pkg::CoordW-1:0]  x_pos_i,
  input  logic [rtyuv_pkg::CoordW-1:0]  y_pos_i,
  input  logic [rtyuv_pkg::FwidthW-1:0] pic_width_i,
  input  logic [1:0]                    chroma_mode_i,
  output rtyuv_pkg::addr_t              addr_o
);
  import rtyuv_pkg::*;

  localparam int unsigned ProdW = CoordW + StrideW;

  logic [StrideW-1:0]  fw_pad;
  logic [StrideW-1:0]  stride;
  logic [StrideW-2:0]  half;
  logic [ProdW-1:0]    row_full;
  logic [ProdW-1:0]    row_half;
  logic [AddrW-1:0]    luma_addr;
  logic [CoordW-2:0]   x_half;
  logic [CoordW-2:0]   y_half;
  chroma_mode_e        mode;

  // Stride is the width padded up to a multiple of 16.
  assign fw_pad = StrideW'(pic_width_i) + StrideW'(15);
  assign stride = {fw_pad[StrideW-1:4], 4'b0000};
  assign half   = stride[StrideW-1:1];
  assign x_half = x_pos_i[CoordW-1:1];
  assign y_half = y_pos_i[CoordW-1:1];

  // Row offsets: full rows at full stride, half rows at half stride.
  assign row_full = ProdW'(y_pos_i) * ProdW'(stride);
  assign row_half = ProdW'(y_half) * ProdW'(half);

  assign luma_addr = AddrW'(row_full + ProdW'(x_pos_i));
  assign mode      = chroma_mode_e'(chroma_mode_i);

  // Chroma sample selection and address by layout.  Since the stride is
  // even, y times half stride is the full row offset shifted right by one.
  always_comb begin
    addr_o.luma_address = luma_addr;
    case (mode)
      CM_420: begin
        addr_o.chroma_write   = ~x_pos_i[0] & ~y_pos_i[0];
        addr_o.chroma_address = AddrW'(row_half + ProdW'(x_half));
      end
      CM_444: begin
        addr_o.chroma_write   = 1'b1;
        addr_o.chroma_address = luma_addr;
      end
      default: begin
        addr_o.chroma_write   = ~x_pos_i[0];
        addr_o.chroma_address = AddrW'((row_full >> 1) + ProdW'(x_half));
      end
    endcase
  end

endmodule

@@ hw/rtl/rgb_to_yuv_planar_subsample.sv @@
// Channel  Dir  Contents
// pix_i    in   x_pos, y_pos, red, green, blue
// res_o    out  luma_address, luma, chroma_write, chroma_address, cb_value, cr_value
// cfg      in   cfg_we_i, cfg_idx_i (0 picture width, 1 chroma_mode), cfg_data_i
//
// One pixel a cycle while the output is not stalled.  An accepted request passes
// through the input register and then the result register, with the color and
// address arithmetic between them.  Reset clears both valid flags and loads
// a picture width of 640 and 4:2:0.  A stall at the output holds both stages, and
// the input stays ready while the input stage can move on.
module rgb_to_yuv_planar_subsample (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtyuv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtyuv_pkg::FwidthW-1:0] cfg_data_i,
  rtyuv_pix_if.sink                     pix_i,
  rtyuv_res_if.source                   res_o
);
  import rtyuv_pkg::*;

  logic [FwidthW-1:0] pic_width_q;
  logic [1:0]         chroma_mode_q;
  logic               in_valid_q;
  pix_t               pix_q, pix_d;
  logic               res_valid_q;
  res_t               res_q, res_d;
  logic               res_free;
  logic               in_free;
  addr_t              addr;
  logic [CompW-1:0]   luma, cb, cr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pic_width_q   <= PicWidthRst;
      chroma_mode_q <= CM_420;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PIC_WIDTH:   pic_width_q   <= cfg_data_i;
        CFG_CHROMA_MODE: chroma_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage moves when the stage after it is empty or drains.
  assign res_free    = ~res_valid_q | res_o.ready;
  assign in_free     = ~in_valid_q | res_free;
  assign pix_i.ready = in_free;

  assign pix_d.x_pos = pix_i.x_pos;
  assign pix_d.y_pos = pix_i.y_pos;
  assign pix_d.red   = pix_i.red;
  assign pix_d.green = pix_i.green;
  assign pix_d.blue  = pix_i.blue;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && pix_i.valid) begin
      pix_q <= pix_d;
    end
  end

  // Color conversion and plane addressing.
  rtyuv_color u_color (
    .red_i   (pix_q.red),
    .green_i (pix_q.green),
    .blue_i  (pix_q.blue),
    .luma_o  (luma),
    .cb_o    (cb),
    .cr_o    (cr)
  );

  rtyuv_addr u_addr (
    .x_pos_i       (pix_q.x_pos),
    .y_pos_i       (pix_q.y_pos),
    .pic_width_i   (pic_width_q),
    .chroma_mode_i (chroma_mode_q),
    .addr_o        (addr)
  );

  // Chroma fields read zero when this pixel supplies no chroma.
  always_comb begin
    res_d.luma_address   = addr.luma_address;
    res_d.luma           = luma;
    res_d.chroma_write   = addr.chroma_write;
    res_d.chroma_address = addr.chroma_write ? addr.chroma_address : '0;
    res_d.cb_value       = addr.chroma_write ? cb : '0;
    res_d.cr_value       = addr.chroma_write ? cr : '0;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.luma_address   = res_q.luma_address;
  assign res_o.luma           = res_q.luma;
  assign res_o.chroma_write   = res_q.chroma_write;
  assign res_o.chroma_address = res_q.chroma_address;
  assign res_o.cb_value       = res_q.cb_value;
  assign res_o.cr_value       = res_q.cr_value;

endmodule

@@ dv/rgb_to_yuv_planar_subsample_test.sv @@
`timescale 1ns / 1ps

module rgb_to_yuv_planar_subsample_test;
  import rtyuv_pkg::*;

  // The unused chroma code, which the block treats as 4:2:2.
  localparam logic [1:0] CmUnused = 2'd3;
  localparam int unsigned PixPerPhase = 150;
  localparam int unsigned HoldCycles = 300;

  // One step of the directed script: a register write or a pixel request.
  typedef struct {
    bit                 is_cfg;
    cfg_idx_e           idx;
    logic [FwidthW-1:0] data;
    pix_t               px;
    bit                 known;
    res_t               want;
  } step_row_t;

  typedef struct {
    int unsigned width;
    logic [1:0]  mode;
  } phase_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we_i;
  cfg_idx_e           cfg_idx_i;
  logic [FwidthW-1:0] cfg_data_i;

  rtyuv_pix_if pix ();
  rtyuv_res_if res ();

  rgb_to_yuv_planar_subsample dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  always #2 clk_i = ~clk_i;

  // Local copy of the two registers, tracking every write.
  logic [FwidthW-1:0] width_q = PicWidthRst;
  logic [1:0]         mode_q  = CM_420;

  res_t        pending_yuv[$];
  int unsigned mismatch_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req = 1'b0;

  // Result handshake and fields as they stand before the coming rising edge.
  bit          out_fire_n = 1'b0;
  res_t        out_seen_n;

  // Q16 sum to an 8-bit sample: negative gives 0, then truncate and limit to 255.
  function automatic logic [CompW-1:0] sat_q16(input longint acc);
    if (acc < 0) return '0;
    acc = acc >>> 16;
    return (acc > 255) ? 8'd255 : CompW'(acc);
  endfunction

  // Expected Y/U/V samples and plane addresses for one pixel.
  function automatic res_t convert_pixel(input pix_t p, input logic [FwidthW-1:0] fw,
                                         input logic [1:0] cm);
    longint r, g, b, x, y, stride, half, caddr;
    bit     wr;
    res_t   o;
    r = p.red;
    g = p.green;
    b = p.blue;
    x = p.x_pos;
    y = p.y_pos;
    stride = (longint'(fw) + 15) & ~longint'(15);
    half = stride >> 1;
    o = '0;
    o.luma_address = AddrW'(x + y * stride);
    o.luma = sat_q16(19595 * r + 38470 * g + 7471 * b);
    if (cm == CM_420) begin
      wr = (x[0] == 1'b0) && (y[0] == 1'b0);
      caddr = (x >> 1) + (y >> 1) * half;
    end else if (cm == CM_444) begin
      wr = 1'b1;
      caddr = x + y * stride;
    end else begin
      wr = (x[0] == 1'b0);
      caddr = (x >> 1) + y * half;
    end
    if (wr) begin
      o.chroma_write = 1'b1;
      o.chroma_address = AddrW'(caddr);
      o.cb_value = sat_q16(8355840 - 11058 * r - 21710 * g + 32768 * b);
      o.cr_value = sat_q16(8355840 + 32768 * r - 27439 * g - 5329 * b);
    end
    return o;
  endfunction

  function automatic pix_t mk_pix(input int x, input int y, input int r, input int g,
                                  input int b);
    return '{x_pos: CoordW'(x), y_pos: CoordW'(y), red: CompW'(r), green: CompW'(g),
             blue: CompW'(b)};
  endfunction

  function automatic step_row_t px_row(input int x, input int y, input int r, input int g,
                                       input int b);
    step_row_t s;
    s.is_cfg = 1'b0;
    s.idx    = CFG_PIC_WIDTH;
    s.data   = '0;
    s.px     = mk_pix(x, y, r, g, b);
    s.known  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic step_row_t known_row(input int x, input int y, input int r,
                                          input int g, input int b, input int la,
                                          input int l, input int cw, input int ca,
                                          input int cb, input int cr);
    step_row_t s;
    s = px_row(x, y, r, g, b);
    s.known = 1'b1;
    s.want = '{luma_address: AddrW'(la), luma: CompW'(l), chroma_write: cw[0],
               chroma_address: AddrW'(ca), cb_value: CompW'(cb), cr_value: CompW'(cr)};
    return s;
  endfunction

  function automatic step_row_t cfg_row(input cfg_idx_e idx, input int data);
    step_row_t s;
    s = px_row(0, 0, 0, 0, 0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = FwidthW'(data);
    return s;
  endfunction

  // Components lean toward the extremes so that clamping is hit often.
  function automatic int rand_comp();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Columns mostly fall inside the picture; some land beyond its width.
  function automatic pix_t rand_pixel(input logic [FwidthW-1:0] fw);
    int lim;
    int x;
    lim = (fw == 0) ? 1 : ((fw > 4096) ? 4096 : int'(fw));
    x = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 4095);
    return mk_pix(x, $urandom_range(0, 4095), rand_comp(), rand_comp(), rand_comp());
  endfunction

  // Sender-side idle cycles before the next request.
  task automatic idle_gap();
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offer one pixel and record its expected result once the request is taken.
  // Ready is sampled on the falling edge, where it holds its value for the next edge.
  task automatic send_pixel(input pix_t p, input res_t want);
    bit taken;
    pix.valid <= 1'b1;
    pix.x_pos <= p.x_pos;
    pix.y_pos <= p.y_pos;
    pix.red   <= p.red;
    pix.green <= p.green;
    pix.blue  <= p.blue;
    do begin
      @(negedge clk_i);
      taken = pix.ready;
      @(posedge clk_i);
    end while (!taken);
    pending_yuv.push_back(want);
  endtask

  // Stop offering, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    pix.valid <= 1'b0;
    while (pending_yuv.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [FwidthW-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PIC_WIDTH) width_q = data;
    else mode_q = data[1:0];
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Capture the result side while it is stable between rising edges.
  always @(negedge clk_i) begin
    out_fire_n = rst_ni && res.valid && res.ready;
    out_seen_n.luma_address   = res.luma_address;
    out_seen_n.luma           = res.luma;
    out_seen_n.chroma_write   = res.chroma_write;
    out_seen_n.chroma_address = res.chroma_address;
    out_seen_n.cb_value       = res.cb_value;
    out_seen_n.cr_value       = res.cr_value;
  end

  // Result side: compare each accepted result, then pick the next ready value.
  always @(posedge clk_i) begin
    res_t want;
    int unsigned hold_left;
    bit hold_done;
    if (out_fire_n) begin
      if (pending_yuv.size() == 0) begin
        $error("result with no pixel outstanding: luma_address %0d",
               out_seen_n.luma_address);
        mismatch_cnt++;
      end else begin
        want = pending_yuv.pop_front();
        check_field("luma_address", want.luma_address, out_seen_n.luma_address);
        check_field("luma", AddrW'(want.luma), AddrW'(out_seen_n.luma));
        check_field("chroma_write", AddrW'(want.chroma_write),
                    AddrW'(out_seen_n.chroma_write));
        check_field("chroma_address", want.chroma_address, out_seen_n.chroma_address);
        check_field("cb_value", AddrW'(want.cb_value), AddrW'(out_seen_n.cb_value));
        check_field("cr_value", AddrW'(want.cr_value), AddrW'(out_seen_n.cr_value));
      end
    end
    // A long hold-off lets the pipeline fill and back-pressure the input.
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Stimulus: directed script under several settings, then random phases.
  initial begin
    step_row_t  script[$];
    phase_cfg_t phases[$];
    pix_t       p;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_PIC_WIDTH;
    cfg_data_i = '0;
    pix.valid  = 1'b0;
    pix.x_pos  = '0;
    pix.y_pos  = '0;
    pix.red    = '0;
    pix.green  = '0;
    pix.blue   = '0;
    res.ready  = 1'b0;

    // The typed-in rows run under the reset setting: width 640, 4:2:0.
    script = '{
      known_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 127, 127),
      known_row(1, 0, 255, 255, 255, 1, 255, 0, 0, 0, 0),
      known_row(2, 2, 0, 0, 255, 1282, 29, 1, 321, 255, 106),
      known_row(4095, 4095, 255, 0, 0, 2624895, 76, 0, 0, 0, 0),
      known_row(4094, 4094, 255, 0, 0, 2624254, 76, 1, 657087, 84, 255),
      known_row(0, 1, 0, 255, 0, 640, 149, 0, 0, 0, 0),
      known_row(4, 0, 0, 255, 0, 4, 149, 1, 2, 43, 20),
      known_row(6, 6, 255, 255, 0, 3846, 225, 1, 963, 0, 148),
      cfg_row(CFG_CHROMA_MODE, CM_422),
      px_row(3, 5, 255, 255, 255),
      px_row(4, 5, 0, 0, 255),
      cfg_row(CFG_CHROMA_MODE, CM_444),
      px_row(7, 9, 255, 0, 0),
      px_row(4095, 0, 0, 255, 0),
      cfg_row(CFG_CHROMA_MODE, CmUnused),
      px_row(1, 1, 12, 200, 77),
      px_row(2, 1, 255, 255, 0),
      cfg_row(CFG_PIC_WIDTH, 0),
      px_row(5, 7, 90, 10, 250),
      cfg_row(CFG_PIC_WIDTH, 1),
      px_row(0, 4095, 0, 255, 255),
      px_row(1, 3, 128, 128, 128),
      cfg_row(CFG_PIC_WIDTH, 8191),
      px_row(4095, 4095, 1, 254, 127),
      px_row(4094, 4094, 255, 0, 255),
      cfg_row(CFG_PIC_WIDTH, 4096),
      cfg_row(CFG_CHROMA_MODE, CM_420),
      px_row(4094, 4094, 0, 0, 0),
      px_row(4095, 4095, 255, 255, 255)
    };

    phases = '{
      '{640, CM_420}, '{1920, CM_422}, '{17, CM_444},
      '{4096, CM_420}, '{8191, CmUnused}, '{1, CM_422},
      '{352, CM_444}, '{4095, CM_420}, '{0, CM_444}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 38;
    snk_idle_pct = 69;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].idx, script[i].data);
      end else begin
        idle_gap();
        send_pixel(script[i].px, script[i].known ? script[i].want
                                                 : convert_pixel(script[i].px, width_q,
                                                                 mode_q));
      end
    end

    // Three phases each of: sender lighter, receiver lighter, no idling.
    foreach (phases[ph]) begin
      write_reg(CFG_PIC_WIDTH, FwidthW'(phases[ph].width));
      write_reg(CFG_CHROMA_MODE, FwidthW'(phases[ph].mode));
      case (ph / 3)
        0: begin
          src_idle_pct = 38;
          snk_idle_pct = 69;
        end
        1: begin
          src_idle_pct = 69;
          snk_idle_pct = 38;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      if (ph == 6) hold_req = 1'b1;
      repeat (PixPerPhase) begin
        idle_gap();
        p = rand_pixel(width_q);
        send_pixel(p, convert_pixel(p, width_q, mode_q));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a stuck handshake.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ rgb_to_yuv_planar_subsample.f @@
hw/rtl/rtyuv_pkg.sv
hw/rtl/rtyuv_pix_if.sv
hw/rtl/rtyuv_res_if.sv
hw/rtl/rtyuv_color.sv
hw/rtl/rtyuv_addr.sv
hw/rtl/rgb_to_yuv_planar_subsample.sv
dv/rgb_to_yuv_planar_subsample_test.sv
